FILE: rtl/core/bde_pkg.sv
// Shared types and constants for the button debounce and edge hold block.
package bde_pkg;

  // Width of the button byte on the ports and of the tick counters.
  localparam int unsigned BTN_W = 8;
  localparam int unsigned CNT_W = 16;

  // Register map of the configuration port (index is paddr[2]).
  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_HOLD_TIMEOUT   = 1'b1;

  // Register reset values.
  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST = 16'd100;
  localparam logic [CNT_W-1:0] HOLD_TIMEOUT_RST   = 16'd1000;

  // Saturation value of the tick counters.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Control from the debounce path to the change timer.
  typedef struct packed {
    logic step;    // a tick is being processed this cycle
    logic change;  // the debounced status changes on this tick
  } timer_ctl_t;

  // Timer outcome for the tick being processed.
  typedef struct packed {
    logic fired;
  } timer_evt_t;

endpackage

FILE: rtl/core/bde_timer.sv
// Shared post-change timer that fires at most one event per debounced status change.
module bde_timer
  import bde_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  timer_ctl_t       ctl,
  input  logic [CNT_W-1:0] hold_timeout,
  output timer_evt_t       evt
);

  logic [CNT_W-1:0] since_change;
  logic             change_armed;
  logic [CNT_W-1:0] since_change_next;
  logic             armed_pre;
  logic             fired;

  // A change restarts the count; otherwise it advances and saturates.
  always_comb begin
    if (ctl.change) begin
      since_change_next = '0;
    end else if (since_change == CNT_MAX) begin
      since_change_next = since_change;
    end else begin
      since_change_next = since_change + 1'b1;
    end
    armed_pre = ctl.change | change_armed;
    fired     = armed_pre && (since_change_next > hold_timeout);
  end

  assign evt.fired = fired;

  // The event disarms the timer until the next change.
  always_ff @(posedge clk) begin
    if (rst) begin
      since_change <= '0;
      change_armed <= 1'b0;
    end else if (ctl.step) begin
      since_change <= since_change_next;
      change_armed <= armed_pre & ~fired;
    end
  end

endmodule

FILE: rtl/core/button_debounce_edge_hold_core.sv
// Top level of the button debounce block with edge detect and hold timer.
// Timing: a result is registered and valid in the cycle after its input transaction is accepted.
// Throughput: one tick per cycle; the single output register is refilled in the
// same cycle that its result is taken, so in_ready only drops while it is stalled.
// Reset: synchronous; clears the status, candidate, timer, output valid, and
// sets debounce_ticks to 100 and hold_timeout to 1000.
module button_debounce_edge_hold_core
  import bde_pkg::*;
#(
  parameter int unsigned BUTTONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel.
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [BTN_W-1:0] raw_buttons,
  // Output channel.
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BTN_W-1:0] pressed,
  output logic [BTN_W-1:0] down_edges,
  output logic [BTN_W-1:0] up_edges,
  output logic [BTN_W-1:0] last_released,
  output logic             timer_fired,
  output logic [BTN_W-1:0] held_buttons,
  output logic [BTN_W-1:0] released_ago
);

  logic [CNT_W-1:0]   debounce_ticks;
  logic [CNT_W-1:0]   hold_timeout;

  logic [BUTTONS-1:0] debounced_status;
  logic [BUTTONS-1:0] candidate_pattern;
  logic [CNT_W-1:0]   candidate_age;
  logic [BUTTONS-1:0] released_at_change;

  logic [BUTTONS-1:0] sample;
  logic [BUTTONS-1:0] debounced_status_next;
  logic [BUTTONS-1:0] candidate_pattern_next;
  logic [CNT_W-1:0]   candidate_age_next;
  logic [CNT_W-1:0]   age_inc;
  logic [BUTTONS-1:0] released_at_change_next;
  logic [BUTTONS-1:0] rise;
  logic [BUTTONS-1:0] fall;
  logic               accept;
  logic               cfg_write;

  timer_ctl_t         tmr_ctl;
  timer_evt_t         tmr_evt;

  // Configuration registers; the register index is address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_TICKS_RST;
      hold_timeout   <= HOLD_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[CNT_W-1:0];
        REG_HOLD_TIMEOUT:   hold_timeout   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE_TICKS: prdata = 32'(debounce_ticks);
      REG_HOLD_TIMEOUT:   prdata = 32'(hold_timeout);
      default:            prdata = '0;
    endcase
  end

  // Handshake: a new tick enters whenever the output register is free or drains.
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // Debounce: a differing pattern must outlast debounce_ticks to be accepted.
  assign sample  = ~raw_buttons[BUTTONS-1:0];
  assign age_inc = (candidate_age == CNT_MAX) ? candidate_age : candidate_age + 1'b1;

  always_comb begin
    debounced_status_next  = debounced_status;
    candidate_pattern_next = candidate_pattern;
    candidate_age_next     = candidate_age;
    if (sample != debounced_status) begin
      if (sample == candidate_pattern) begin
        candidate_age_next = age_inc;
        if (age_inc > debounce_ticks) begin
          debounced_status_next = sample;
        end
      end else begin
        candidate_pattern_next = sample;
        candidate_age_next     = '0;
      end
    end else begin
      candidate_pattern_next = debounced_status;
      candidate_age_next     = '0;
    end
  end

  // Edges against the previous status and the release mask of the last change.
  assign rise = debounced_status_next & ~debounced_status;
  assign fall = debounced_status & ~debounced_status_next;
  assign released_at_change_next =
      (debounced_status_next != debounced_status) ? fall : released_at_change;

  assign tmr_ctl.step   = accept;
  assign tmr_ctl.change = (debounced_status_next != debounced_status);

  bde_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .ctl          (tmr_ctl),
    .hold_timeout (hold_timeout),
    .evt          (tmr_evt)
  );

  // Debounce state advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_status   <= '0;
      candidate_pattern  <= '0;
      candidate_age      <= '0;
      released_at_change <= '0;
    end else if (accept) begin
      debounced_status   <= debounced_status_next;
      candidate_pattern  <= candidate_pattern_next;
      candidate_age      <= candidate_age_next;
      released_at_change <= released_at_change_next;
    end
  end

  // Output register: valid is control state, the payload is loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pressed       <= BTN_W'(debounced_status_next);
      down_edges    <= BTN_W'(rise);
      up_edges      <= BTN_W'(fall);
      last_released <= BTN_W'(released_at_change_next);
      timer_fired   <= tmr_evt.fired;
      held_buttons  <= tmr_evt.fired ? BTN_W'(debounced_status_next) : '0;
      released_ago  <= tmr_evt.fired ? BTN_W'(released_at_change_next) : '0;
    end
  end

endmodule

FILE: rtl/core/bde_checker.sv
// Port-level checker for the button debounce block and its bind statement.
module bde_checker
  import bde_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [BTN_W-1:0] pressed,
  input logic [BTN_W-1:0] down_edges,
  input logic [BTN_W-1:0] up_edges,
  input logic             timer_fired,
  input logic [BTN_W-1:0] held_buttons,
  input logic [BTN_W-1:0] released_ago
);

  // A stalled result holds its status.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressed))
    else $error("stalled result changed");

  // A button cannot both rise and fall on the same tick.
  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (down_edges & up_edges) == '0)
    else $error("press and release edge on the same button");

  // Press edges are pressed now; release edges are released now.
  a_edges_match_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((down_edges & ~pressed) == '0) && ((up_edges & pressed) == '0))
    else $error("edge disagrees with the debounced status");

  // The event masks are zero unless the timer fired, and the held mask is the status.
  a_event_masks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (timer_fired ? (held_buttons == pressed)
                               : (held_buttons == '0 && released_ago == '0)))
    else $error("event masks inconsistent with timer_fired");

endmodule

bind button_debounce_edge_hold_core bde_checker u_bde_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pressed      (pressed),
  .down_edges   (down_edges),
  .up_edges     (up_edges),
  .timer_fired  (timer_fired),
  .held_buttons (held_buttons),
  .released_ago (released_ago)
);

FILE: tb/sv/bde_tick_checker.sv
// Checker that predicts and compares every result of the button debounce block.
`timescale 1ns / 100ps

module bde_tick_checker
  import bde_pkg::*;
#(
  parameter int unsigned BUTTONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration port, watched for register writes.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  // Input channel.
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [BTN_W-1:0] raw_buttons,
  // Output channel.
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [BTN_W-1:0] pressed,
  input  logic [BTN_W-1:0] down_edges,
  input  logic [BTN_W-1:0] up_edges,
  input  logic [BTN_W-1:0] last_released,
  input  logic             timer_fired,
  input  logic [BTN_W-1:0] held_buttons,
  input  logic [BTN_W-1:0] released_ago,
  output int               errors,
  output int               pending
);

  // One expected result per accepted tick.
  typedef struct packed {
    logic [BTN_W-1:0] pressed;
    logic [BTN_W-1:0] down_edges;
    logic [BTN_W-1:0] up_edges;
    logic [BTN_W-1:0] last_released;
    logic             timer_fired;
    logic [BTN_W-1:0] held_buttons;
    logic [BTN_W-1:0] released_ago;
  } tick_result_t;

  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((1 << BUTTONS) - 1);

  // Shadow copy of the registers and of the debounce state.
  logic [CNT_W-1:0] debounce_ticks;
  logic [CNT_W-1:0] hold_timeout;
  logic [BTN_W-1:0] status;
  logic [BTN_W-1:0] cand_pattern;
  logic [CNT_W-1:0] cand_age;
  logic [BTN_W-1:0] released_at_change;
  logic [CNT_W-1:0] since_change;
  logic             change_armed;

  tick_result_t expected_ticks[$];

  // Advances the shadow state by one tick and returns the result it yields.
  function automatic tick_result_t predict_tick(input logic [BTN_W-1:0] raw);
    tick_result_t     res;
    logic [BTN_W-1:0] sample;
    logic [BTN_W-1:0] prev;
    logic             fire;
    sample = ~raw & BTN_MASK;
    prev   = status;
    if (sample != status) begin
      if (sample == cand_pattern) begin
        if (cand_age != CNT_MAX) cand_age = cand_age + 1'b1;
        if (cand_age > debounce_ticks) status = sample;
      end else begin
        cand_pattern = sample;
        cand_age     = '0;
      end
    end else begin
      cand_pattern = status;
      cand_age     = '0;
    end
    // A status change restarts the shared timer and arms its single event.
    if (status != prev) begin
      released_at_change = prev & ~status;
      since_change       = '0;
      change_armed       = 1'b1;
    end else if (since_change != CNT_MAX) begin
      since_change = since_change + 1'b1;
    end
    fire = change_armed && (since_change > hold_timeout);
    if (fire) change_armed = 1'b0;
    res.pressed       = status;
    res.down_edges    = status & ~prev;
    res.up_edges      = prev & ~status;
    res.last_released = released_at_change;
    res.timer_fired   = fire;
    res.held_buttons  = fire ? status : '0;
    res.released_ago  = fire ? released_at_change : '0;
    return res;
  endfunction

  task automatic check_field(input string fname, input logic [BTN_W-1:0] exp_v,
                             input logic [BTN_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %02h actual %02h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Follow reset, register writes and both channels at each rising edge.
  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      debounce_ticks     = DEBOUNCE_TICKS_RST;
      hold_timeout       = HOLD_TIMEOUT_RST;
      status             = '0;
      cand_pattern       = '0;
      cand_age           = '0;
      released_at_change = '0;
      since_change       = '0;
      change_armed       = 1'b0;
      expected_ticks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DEBOUNCE_TICKS) debounce_ticks = pwdata[CNT_W-1:0];
        else hold_timeout = pwdata[CNT_W-1:0];
      end
      // Compare the result transaction before queuing a new tick.
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result transaction with nothing expected, pressed %02h",
                   $time, pressed);
          errors++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("pressed", want.pressed, pressed);
          check_field("down_edges", want.down_edges, down_edges);
          check_field("up_edges", want.up_edges, up_edges);
          check_field("last_released", want.last_released, last_released);
          check_field("timer_fired", BTN_W'(want.timer_fired), BTN_W'(timer_fired));
          check_field("held_buttons", want.held_buttons, held_buttons);
          check_field("released_ago", want.released_ago, released_ago);
        end
      end
      if (in_valid && in_ready) expected_ticks.push_back(predict_tick(raw_buttons));
    end
    pending = expected_ticks.size();
  end

endmodule

FILE: tb/sv/button_debounce_edge_hold_core_tb.sv
// Testbench top: drives ticks and register writes into the debounce block.
`timescale 1ns / 100ps

module button_debounce_edge_hold_core_tb
  import bde_pkg::*;
;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASES          = 10;
  localparam int PHASE_TICKS     = 85;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid;
  logic             in_ready;
  logic [BTN_W-1:0] raw_buttons;
  logic             out_valid;
  logic             out_ready;
  logic [BTN_W-1:0] pressed;
  logic [BTN_W-1:0] down_edges;
  logic [BTN_W-1:0] up_edges;
  logic [BTN_W-1:0] last_released;
  logic             timer_fired;
  logic [BTN_W-1:0] held_buttons;
  logic [BTN_W-1:0] released_ago;

  int errors;
  int pending;
  int gap_pct;
  int stall_pct;
  int quiet_cycles;

  button_debounce_edge_hold_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .raw_buttons(raw_buttons),
    .out_valid(out_valid), .out_ready(out_ready), .pressed(pressed),
    .down_edges(down_edges), .up_edges(up_edges), .last_released(last_released),
    .timer_fired(timer_fired), .held_buttons(held_buttons),
    .released_ago(released_ago)
  );

  bde_tick_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .raw_buttons(raw_buttons),
    .out_valid(out_valid), .out_ready(out_ready), .pressed(pressed),
    .down_edges(down_edges), .up_edges(up_edges), .last_released(last_released),
    .timer_fired(timer_fired), .held_buttons(held_buttons),
    .released_ago(released_ago),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random with the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("button_debounce_edge_hold_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Setup and access cycle of one register write; called at a falling edge,
  // returns at the falling edge after the access cycle with psel still high.
  task automatic write_reg(input logic regsel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
  endtask

  // Sends one tick, with random idle cycles before it; valid stays high on return.
  task automatic send_tick(input logic [BTN_W-1:0] raw);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    raw_buttons <= raw;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_regs(input int dbt, input int hold);
    wait_idle();
    write_reg(REG_DEBOUNCE_TICKS, dbt);
    write_reg(REG_HOLD_TIMEOUT, hold);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Held patterns with occasional one-bit bounces; long holds let the timer fire.
  task automatic run_phase(input int dbt, input int hold, input int mode, input int n);
    logic [BTN_W-1:0] target;
    int               run_len;
    int               sent;
    begin
      set_regs(dbt, hold);
      gap_pct   = (mode == 1) ? 69 : (mode == 3) ? 19 : 0;
      stall_pct = (mode == 2) ? 69 : (mode == 3) ? 19 : 0;
      target    = BTN_W'($urandom);
      sent      = 0;
      while (sent < n) begin
        if (dbt < 16 && hold < 64 && $urandom_range(99) < 30) run_len = dbt + hold + 3;
        else if (dbt < 16) run_len = $urandom_range(1, dbt + 3);
        else run_len = $urandom_range(1, 6);
        for (int k = 0; k < run_len && sent < n; k++) begin
          if ($urandom_range(99) < 10) send_tick(target ^ (BTN_W'(1) << $urandom_range(BTN_W - 1)));
          else send_tick(target);
          sent++;
        end
        case ($urandom_range(3))
          0: target = target ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
          1: target = '1;
          default: target = BTN_W'($urandom);
        endcase
      end
    end
  endtask

  // Directed ticks first, then random phases over several register settings.
  initial begin
    int dbt_list[PHASES]  = '{0, 1, 2, 0, 3, 65535, 4, 1, 0, 0};
    int hold_list[PHASES] = '{0, 2, 3, 65535, 0, 1, 6, 0, 0, 0};
    logic [BTN_W-1:0] walk[14] = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hAA,
                                   8'hAA, 8'h55, 8'h55, 8'h55, 8'h7F, 8'hFE, 8'hFE};
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    raw_buttons = '1;
    gap_pct     = 0;
    stall_pct   = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a long debounce keeps every change pending.
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h00);

    // Zero debounce and zero timeout: quick presses, releases and events.
    set_regs(0, 0);
    foreach (walk[i]) send_tick(walk[i]);

    // Largest settings: nothing is ever accepted and the timer never fires.
    set_regs(65535, 65535);
    repeat (4) send_tick(8'h00);

    dbt_list[8]  = $urandom_range(0, 5);
    hold_list[8] = $urandom_range(0, 12);
    dbt_list[9]  = $urandom_range(0, 5);
    hold_list[9] = $urandom_range(0, 12);
    for (int p = 0; p < PHASES; p++) run_phase(dbt_list[p], hold_list[p], p % 4, PHASE_TICKS);

    wait_idle();
    repeat (5) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("button_debounce_edge_hold_core: match");
    end else begin
      $display("button_debounce_edge_hold_core: mismatch");
    end
    $finish;
  end

endmodule
